>>> hw/rtl/bite_jerk_density_detector_assert.svh
// Assertion macros for the bite jerk density detector.
// Expects clk and rst_n in the including scope; no other dependencies.
`ifndef BITE_JERK_DENSITY_DETECTOR_ASSERT_SVH
`define BITE_JERK_DENSITY_DETECTOR_ASSERT_SVH

// same-cycle implication
`define BJD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bjd assertion failed");

// next-cycle implication
`define BJD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bjd assertion failed");

`endif

>>> hw/rtl/bjd_pkg.sv
// Package for the bite jerk density detector: field widths, register
// indexes and reset values. No dependencies.
package bjd_pkg;

  localparam int ACC_W   = 16;
  localparam int TICK_W  = 32;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 31;
  localparam int WIN_W   = 7;
  localparam int THR_W   = 32;
  localparam int HOLD_W  = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int WINDOW_MAX_DEF = 64;
  localparam int WIN_FIELD_MAX  = (1 << WIN_W) - 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITE_THR     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_THR  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 8'd3;

  // reset values
  localparam logic [WIN_W-1:0]  WINDOW_SIZE_RST = 7'd32;
  localparam logic [THR_W-1:0]  BITE_THR_RST    = 32'd0;
  localparam logic [WIN_W-1:0]  DENSITY_THR_RST = 7'd8;
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST  = 16'd5000;

endpackage

>>> hw/rtl/bjd_ifs.sv
// Channel interfaces of the bite jerk density detector: sample input,
// result output and configuration write. Depends on bjd_pkg.
interface bjd_in_if import bjd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ACC_W-1:0]  accel_x;
  logic signed [ACC_W-1:0]  accel_y;
  logic signed [ACC_W-1:0]  accel_z;
  logic [TICK_W-1:0]        now_tick;

  modport source (output valid, accel_x, accel_y, accel_z, now_tick, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, now_tick, output ready);
endinterface

interface bjd_out_if import bjd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               caught;
  logic [WIN_W-1:0]   hit_count;
  logic [MAG_W-1:0]   jerk;

  modport source (output valid, caught, hit_count, jerk, input ready);
  modport sink   (input valid, caught, hit_count, jerk, output ready);
endinterface

interface bjd_cfg_if import bjd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    index;
  logic [CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bite_jerk_density_detector.sv
// Bite jerk density detector: jerk of accelerometer magnitude, hit density
// over a sliding window, caught flag with hold time.
// Depends on bjd_pkg, bjd_ifs and bite_jerk_density_detector_assert.svh.
//
// Usage:
//  - in_ch carries one sample per transaction (accel_x/y/z, now_tick).
//  - out_ch returns exactly one result per sample (caught, hit_count, jerk),
//    in order.
//  - cfg_ch writes a register by index (0 window_size, 1 bite_thr,
//    2 density_thr, 3 hold_ticks); other indexes are dropped. cfg_ch
//    is always ready; write it only with no sample in flight.
//  - Throughput: one sample per cycle while out_ch does not stall. Results
//    pass stage 1, stage 2, stage 3 and the output register before out_ch.
//  - Pipeline: squares, magnitude sum, jerk/ring read, count update/ring
//    write, output register. The hit ring is a 1-bit synchronous memory of
//    WINDOW_MAX entries; its read is issued one stage before the write-back,
//    and a write to the same entry in that cycle is forwarded.
//  - Reset (synchronous, rst_n low) restores register defaults, empties the
//    ring and unprimes the detector. The ring is emptied by zeroing the write
//    position, the count and a wrapped flag: until the write position wraps,
//    the entry it points at reads as zero. Writing window_size does the same.
//  - When out_ch stalls, the whole pipeline holds and in_ch.ready drops only
//    while a result sits in the output register and is not being taken.
module bite_jerk_density_detector
  import bjd_pkg::*;
#(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bjd_in_if.sink     in_ch,
  bjd_out_if.source  out_ch,
  bjd_cfg_if.sink    cfg_ch
);

  localparam int AW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW        = (AW + 1 > WIN_W) ? AW + 1 : WIN_W;
  localparam int WIN_CLAMP = (WINDOW_MAX < WIN_FIELD_MAX) ? WINDOW_MAX : WIN_FIELD_MAX;

  // configuration registers
  logic [WIN_W-1:0]  window_size_r;
  logic [THR_W-1:0]  bite_thr_r;
  logic [WIN_W-1:0]  density_thr_r;
  logic [HOLD_W-1:0] hold_ticks_r;

  // detector state
  logic              primed_r;
  logic [MAG_W-1:0]  prev_mag_r;
  logic [AW-1:0]     wp_r;
  logic [WIN_W-1:0]  hit_cnt_r;
  logic              caught_r;
  logic [TICK_W-1:0] stamp_r;

  // hit ring: memory plus a flag set once the write position has wrapped
  logic              ring_mem [WINDOW_MAX];
  logic              lap_r;
  logic              rd_bit_r;
  logic              rd_vld_r;
  logic              fwd_r;
  logic              fwd_bit_r;

  // pipeline stage 1: squares
  logic              s1_v_r, s1_prime_r;
  logic [SQ_W-1:0]   s1_sqx_r, s1_sqy_r, s1_sqz_r;
  logic [TICK_W-1:0] s1_tick_r;
  // stage 2: magnitude
  logic              s2_v_r, s2_prime_r;
  logic [MAG_W-1:0]  s2_mag_r;
  logic [TICK_W-1:0] s2_tick_r;
  // stage 3: jerk, ring read data available
  logic              s3_v_r, s3_prime_r;
  logic [MAG_W-1:0]  s3_jerk_r;
  logic [AW-1:0]     s3_pos_r;
  logic [TICK_W-1:0] s3_tick_r;
  // output register
  logic              out_v_r;
  logic              out_caught_r;
  logic [WIN_W-1:0]  out_cnt_r;
  logic [MAG_W-1:0]  out_jerk_r;

  logic              advance;
  logic              in_acc;
  logic              cfg_acc;
  logic              win_clr;
  logic [WIN_W-1:0]  size_eff;
  logic              size_nz;
  logic signed [2*ACC_W-1:0] px, py, pz;
  logic [MAG_W-1:0]  mag_sum;
  logic [MAG_W-1:0]  jerk_calc;
  logic [PW-1:0]     wp_inc;
  logic              wp_wrap;
  logic [AW-1:0]     wp_nxt;
  logic              s3_hit;
  logic              s3_old;
  logic              s3_wr;
  logic [WIN_W-1:0]  cnt_upd;
  logic [WIN_W-1:0]  cnt_nxt;
  logic              caught_nxt;
  logic [TICK_W-1:0] stamp_nxt;
  logic [TICK_W-1:0] since_stamp;

  assign advance  = !out_v_r || out_ch.ready;
  assign in_acc   = in_ch.valid && advance;
  assign cfg_acc  = cfg_ch.valid;
  assign win_clr  = cfg_acc && (cfg_ch.index == REG_WINDOW_SIZE);

  assign in_ch.ready   = advance;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_v_r;
  assign out_ch.caught = out_caught_r;
  assign out_ch.hit_count = out_cnt_r;
  assign out_ch.jerk   = out_jerk_r;

  // oversized window is clamped to the ring depth or the field maximum, whichever is smaller
  assign size_eff = (window_size_r > WIN_W'(WIN_CLAMP)) ? WIN_W'(WIN_CLAMP) : window_size_r;
  assign size_nz  = (size_eff != '0);

  // stage 0/1 arithmetic
  assign px = in_ch.accel_x * in_ch.accel_x;
  assign py = in_ch.accel_y * in_ch.accel_y;
  assign pz = in_ch.accel_z * in_ch.accel_z;
  assign mag_sum = MAG_W'(s1_sqx_r) + MAG_W'(s1_sqy_r) + MAG_W'(s1_sqz_r);

  // stage 2: jerk and write-position advance
  assign jerk_calc = s2_prime_r ? '0 :
                     (s2_mag_r >= prev_mag_r) ? (s2_mag_r - prev_mag_r)
                                              : (prev_mag_r - s2_mag_r);
  assign wp_inc  = PW'(wp_r) + PW'(1);
  assign wp_wrap = (wp_inc >= PW'(size_eff));
  assign wp_nxt  = wp_wrap ? '0 : wp_inc[AW-1:0];

  // stage 3: hit bit, running count, caught flag
  assign s3_hit = (s3_jerk_r > bite_thr_r);
  assign s3_old = fwd_r ? fwd_bit_r : (rd_vld_r && rd_bit_r);
  assign s3_wr  = advance && s3_v_r && !s3_prime_r && size_nz;
  assign cnt_upd = hit_cnt_r - WIN_W'(s3_old) + WIN_W'(s3_hit);
  assign since_stamp = s3_tick_r - stamp_r;

  always_comb begin
    cnt_nxt    = hit_cnt_r;
    caught_nxt = caught_r;
    stamp_nxt  = stamp_r;
    if (!s3_prime_r) begin
      if (size_nz) begin
        cnt_nxt = cnt_upd;
      end
      if (cnt_nxt >= density_thr_r) begin
        // fresh catch: stamp is now, so the hold test cannot clear it
        caught_nxt = 1'b1;
        stamp_nxt  = s3_tick_r;
      end else if (caught_r && (since_stamp > TICK_W'(hold_ticks_r))) begin
        caught_nxt = 1'b0;
      end
    end
  end

  // ring memory: one write port (stage 3), one registered read (stage 2)
  always_ff @(posedge clk) begin
    if (s3_wr) begin
      ring_mem[s3_pos_r] <= s3_hit;
    end
    if (advance) begin
      rd_bit_r <= ring_mem[wp_r];
    end
  end

  // pipeline payload, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sqx_r   <= px[SQ_W-1:0];
      s1_sqy_r   <= py[SQ_W-1:0];
      s1_sqz_r   <= pz[SQ_W-1:0];
      s1_tick_r  <= in_ch.now_tick;
      s1_prime_r <= !primed_r;
      s2_mag_r   <= mag_sum;
      s2_tick_r  <= s1_tick_r;
      s2_prime_r <= s1_prime_r;
      s3_jerk_r  <= jerk_calc;
      s3_tick_r  <= s2_tick_r;
      s3_prime_r <= s2_prime_r;
      s3_pos_r   <= wp_r;
      // a write to the entry being read this cycle wins over memory data
      fwd_r      <= s3_wr && (s3_pos_r == wp_r);
      fwd_bit_r  <= s3_hit;
      if (s3_v_r) begin
        out_caught_r <= caught_nxt;
        out_cnt_r    <= cnt_nxt;
        out_jerk_r   <= s3_jerk_r;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RST;
      bite_thr_r    <= BITE_THR_RST;
      density_thr_r <= DENSITY_THR_RST;
      hold_ticks_r  <= HOLD_TICKS_RST;
      primed_r      <= 1'b0;
      prev_mag_r    <= '0;
      wp_r          <= '0;
      hit_cnt_r     <= '0;
      caught_r      <= 1'b0;
      stamp_r       <= '0;
      lap_r         <= 1'b0;
      rd_vld_r      <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      s3_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      if (advance) begin
        s1_v_r   <= in_acc;
        s2_v_r   <= s1_v_r;
        s3_v_r   <= s2_v_r;
        out_v_r  <= s3_v_r;
        // entry at the write position was written only if the ring wrapped
        rd_vld_r <= lap_r;
        if (in_acc) begin
          primed_r <= 1'b1;
        end
        if (s2_v_r) begin
          prev_mag_r <= s2_mag_r;
        end
        if (s3_v_r) begin
          caught_r  <= caught_nxt;
          stamp_r   <= stamp_nxt;
        end
      end
      // window write empties the ring; user keeps it off any sample in flight (unchecked)
      if (win_clr) begin
        wp_r      <= '0;
        hit_cnt_r <= '0;
        lap_r     <= 1'b0;
      end else if (advance) begin
        if (s2_v_r && !s2_prime_r && size_nz) begin
          wp_r <= wp_nxt;
          if (wp_wrap) begin
            lap_r <= 1'b1;
          end
        end
        if (s3_v_r) begin
          hit_cnt_r <= cnt_nxt;
        end
      end
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_WINDOW_SIZE: window_size_r <= cfg_ch.data[WIN_W-1:0];
          REG_BITE_THR:    bite_thr_r    <= cfg_ch.data[THR_W-1:0];
          REG_DENSITY_THR: density_thr_r <= cfg_ch.data[WIN_W-1:0];
          REG_HOLD_TICKS:  hold_ticks_r  <= cfg_ch.data[HOLD_W-1:0];
          default: ;
        endcase
      end
    end
  end

`include "bite_jerk_density_detector_assert.svh"

  // running count never exceeds the window
  `BJD_ASSERT_NOW(a_cnt_in_window, 1'b1, hit_cnt_r <= size_eff)
  // write position stays inside the window
  `BJD_ASSERT_NOW(a_wp_in_window, size_nz, PW'(wp_r) < PW'(size_eff))
  // a catch is only raised when the count meets the density threshold
  `BJD_ASSERT_NOW(a_catch_density, $rose(caught_r), hit_cnt_r >= density_thr_r)
  // a held result blocks new samples
  `BJD_ASSERT_NOW(a_stall_blocks_input, out_v_r && !out_ch.ready, !in_ch.ready)

endmodule

>>> sim/tb.sv
// Self-checking testbench for bite_jerk_density_detector: drives samples with
// random gaps and output stalls and predicts every result in a scoreboard class.
// Depends on bjd_pkg and the bjd_in_if, bjd_out_if and bjd_cfg_if interfaces.
module tb import bjd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // No transaction on any channel for this many cycles means a hang.
  localparam int QUIET_LIMIT = 5000;
  // Receiver hold-off used to back the pipeline up into the input.
  localparam int STALL_CYCLES = 400;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_PRINTED = 40;

  // Indexes past the register list; the block must drop these writes.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

  typedef struct {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
    logic [TICK_W-1:0]       tick;
  } sample_t;

  typedef struct {
    logic             caught;
    logic [WIN_W-1:0] hit_count;
    logic [MAG_W-1:0] jerk;
  } catch_result_t;

  // Stimulus runs: random noise, large magnitude swings, or near-still samples.
  typedef enum int {RUN_NOISE, RUN_JERKY, RUN_CALM} run_mode_t;

  // Predicts the caught flag, hit count and jerk of every sample, keeps the
  // results still owed by the block and compares the ones that come out.
  class catch_scoreboard;
    logic [WIN_W-1:0]          win_size;
    logic [THR_W-1:0]          bite_thr;
    logic [WIN_W-1:0]          dens_thr;
    logic [HOLD_W-1:0]         hold;
    logic [WINDOW_MAX_DEF-1:0] ring_bits;
    int unsigned               ring_ptr;
    logic [WIN_W-1:0]          ring_hits;
    logic [MAG_W-1:0]          last_mag;
    bit                        seen_first;
    bit                        flag;
    logic [TICK_W-1:0]         flag_tick;
    catch_result_t             pending_results[$];
    int                        errors;

    function new();
      win_size   = WINDOW_SIZE_RST;
      bite_thr   = BITE_THR_RST;
      dens_thr   = DENSITY_THR_RST;
      hold       = HOLD_TICKS_RST;
      ring_bits  = '0;
      ring_ptr   = 0;
      ring_hits  = '0;
      last_mag   = '0;
      seen_first = 1'b0;
      flag       = 1'b0;
      flag_tick  = '0;
      errors     = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_SIZE: begin
          // any window write empties the ring, same value or not
          win_size  = data[WIN_W-1:0];
          ring_bits = '0;
          ring_ptr  = 0;
          ring_hits = '0;
        end
        REG_BITE_THR:    bite_thr = data[THR_W-1:0];
        REG_DENSITY_THR: dens_thr = data[WIN_W-1:0];
        REG_HOLD_TICKS:  hold = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      longint            sx, sy, sz;
      logic [MAG_W-1:0]  mag;
      logic [MAG_W-1:0]  jerk;
      logic [TICK_W-1:0] elapsed;
      int unsigned       eff, pos;
      bit                hit;
      catch_result_t     r;
      sx = s.x;
      sy = s.y;
      sz = s.z;
      mag = MAG_W'(sx * sx + sy * sy + sz * sz);
      jerk = '0;
      if (!seen_first) begin
        // first sample after reset only primes the magnitude
        last_mag   = mag;
        seen_first = 1'b1;
      end else begin
        eff = (win_size > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_size;
        jerk = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
        last_mag = mag;
        if (eff > 0) begin
          pos = (ring_ptr < eff) ? ring_ptr : 0;
          hit = (jerk > bite_thr);
          ring_hits = ring_hits - WIN_W'(ring_bits[pos]) + WIN_W'(hit);
          ring_bits[pos] = hit;
          pos++;
          ring_ptr = (pos >= eff) ? 0 : pos;
        end
        if (ring_hits >= dens_thr) begin
          flag      = 1'b1;
          flag_tick = s.tick;
        end
        elapsed = s.tick - flag_tick;
        if (flag && elapsed > TICK_W'(hold))
          flag = 1'b0;
      end
      r.caught    = flag;
      r.hit_count = ring_hits;
      r.jerk      = jerk;
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED)
        $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic caught, logic [WIN_W-1:0] hit_count, logic [MAG_W-1:0] jerk);
      catch_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result caught=%0d hit_count=%0d jerk=%0d",
                         caught, hit_count, jerk));
        return;
      end
      want = pending_results.pop_front();
      if (caught !== want.caught)
        report($sformatf("caught got %0d want %0d", caught, want.caught));
      if (hit_count !== want.hit_count)
        report($sformatf("hit_count got %0d want %0d", hit_count, want.hit_count));
      if (jerk !== want.jerk)
        report($sformatf("jerk got %0d want %0d", jerk, want.jerk));
    endtask
  endclass

  logic clk;
  logic rst_n;

  bjd_in_if  in_ch ();
  bjd_out_if out_ch ();
  bjd_cfg_if cfg_ch ();

  bite_jerk_density_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  catch_scoreboard sb = new();

  // idle knobs, receiver hold-off request, quiet-cycle count for the watchdog
  bit          send_idle_en;
  bit          recv_idle_en;
  bit          stall_req;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // random stream state
  run_mode_t         run_mode;
  int unsigned       run_left;
  bit                swing;
  logic [TICK_W-1:0] tick_now;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: ready moves at the falling edge. A requested hold-off is
  // counted here so the sender keeps offering while the output backs up.
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req  = 1'b0;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_idle_en && $urandom_range(99) < 25);
    end
  end

  // Result monitor: a transaction is taken at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.caught, out_ch.hit_count, out_ch.jerk);
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("bite_jerk_density_detector verification failed");
      $finish;
    end
  end

  // Offer one sample. Called at a falling edge, returns at a falling edge.
  // valid stays high into the next sample when no gap is drawn, so it is
  // never dropped and raised in the same step.
  task automatic send_sample(input sample_t s);
    while (send_idle_en && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.accel_x  <= s.x;
    in_ch.accel_y  <= s.y;
    in_ch.accel_z  <= s.z;
    in_ch.now_tick <= s.tick;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // Register write transaction; the caller lowers cfg valid after its batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.apply_reg(idx, data);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding result; every sample gives
  // exactly one, so an empty scoreboard means an idle pipeline.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Junk above the register width must be ignored by the block.
  function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned value, int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    return (junk << width) | CFG_DATA_W'(value);
  endfunction

  function automatic sample_t fixed_sample(int x, int y, int z);
    sample_t s;
    s.x = ACC_W'(x);
    s.y = ACC_W'(y);
    s.z = ACC_W'(z);
    tick_now += 16;
    s.tick = tick_now;
    return s;
  endfunction

  // Random samples in runs, so hit density builds up and decays instead of
  // hovering at the average. Ticks mostly creep, sometimes leap past hold.
  function automatic sample_t next_sample();
    sample_t     s;
    int unsigned r;
    if (run_left == 0) begin
      run_mode = run_mode_t'($urandom_range(2));
      run_left = $urandom_range(1, 80);
    end
    run_left--;
    case (run_mode)
      RUN_NOISE: begin
        s.x = ACC_W'($urandom);
        s.y = ACC_W'($urandom);
        s.z = ACC_W'($urandom);
      end
      RUN_JERKY: begin
        swing = !swing;
        if (swing) begin
          s.x = ACC_W'($urandom_range(16000, 32767));
          s.y = ACC_W'($urandom_range(16000, 32767));
          s.z = ACC_W'($urandom_range(16000, 32767));
          if ($urandom_range(1)) s.x = -s.x;
          if ($urandom_range(1)) s.y = -s.y;
          if ($urandom_range(1)) s.z = -s.z;
        end else begin
          s.x = ACC_W'($urandom_range(0, 255));
          s.y = ACC_W'($urandom_range(0, 255));
          s.z = ACC_W'($urandom_range(0, 255));
        end
      end
      default: begin
        s.x = ACC_W'($urandom_range(0, 16)) - 16'd8;
        s.y = ACC_W'($urandom_range(0, 16)) - 16'd8;
        s.z = ACC_W'($urandom_range(0, 16)) - 16'd8;
      end
    endcase
    r = $urandom_range(99);
    if (r < 75)
      tick_now += $urandom_range(0, 300);
    else if (r < 95)
      tick_now += $urandom_range(300, 9000);
    else if (r < 99)
      tick_now += $urandom_range(9000, 100000);
    else
      tick_now = $urandom;
    s.tick = tick_now;
    return s;
  endfunction

  // Register set per phase: fixed corners first (empty, single-entry and
  // oversized windows, thresholds that can never or always be met, both hold
  // extremes), then random settings biased toward small windows.
  task automatic program_phase(input int p);
    int unsigned win, bite, dens, hold, eff;
    case (p)
      0: begin win = 64;  bite = 1000;         dens = 10; hold = 0;     end
      1: begin win = 0;   bite = 0;            dens = 0;  hold = 100;   end
      2: begin win = 1;   bite = 0;            dens = 1;  hold = 65535; end
      3: begin win = 127; bite = 0;            dens = 64; hold = 2000;  end
      4: begin win = 64;  bite = 32'hC0000000; dens = 1;  hold = 1000;  end
      5: begin win = 100; bite = 32'hFFFFFFFF; dens = 0;  hold = 0;     end
      default: begin
        win  = ($urandom_range(99) < 50) ? $urandom_range(1, 16) : $urandom_range(0, 127);
        eff  = (win > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win;
        bite = ($urandom_range(99) < 70) ? $urandom_range(0, 32'h000F_FFFF) : $urandom;
        dens = $urandom_range(0, eff + 2);
        hold = ($urandom_range(99) < 70) ? $urandom_range(0, 3000) : $urandom_range(0, 65535);
      end
    endcase
    write_reg(REG_WINDOW_SIZE, with_noise(win, WIN_W));
    write_reg(REG_BITE_THR, bite);
    write_reg(REG_DENSITY_THR, with_noise(dens, WIN_W));
    write_reg(REG_HOLD_TICKS, with_noise(hold, HOLD_W));
    if (p == 0) begin
      write_reg(REG_UNUSED_LO, $urandom);
      write_reg(REG_UNUSED_HI, $urandom);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mid-phase poke with the pipeline drained: rewrite the same window size
  // (ring must empty), move only the bite threshold (stored hits must keep
  // their old verdicts) or write past the register list (no effect).
  task automatic mid_phase(input int p);
    settle();
    case (p % 3)
      0:       write_reg(REG_WINDOW_SIZE, with_noise(sb.win_size, WIN_W));
      1:       write_reg(REG_BITE_THR, $urandom_range(0, 32'h0010_0000));
      default: write_reg(REG_UNUSED_LO, $urandom);
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.accel_x   = '0;
    in_ch.accel_y   = '0;
    in_ch.accel_z   = '0;
    in_ch.now_tick  = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    send_idle_en    = 1'b1;
    recv_idle_en    = 1'b1;
    stall_req       = 1'b0;
    stall_left      = 0;
    quiet_cycles    = 0;
    run_left        = 0;
    swing           = 1'b0;
    // start just short of the wrap so the directed ticks cross zero
    tick_now        = 32'hFFFF_FFC0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on reset defaults. The first sample only primes; the
    // rest hit full-scale swings, equal magnitudes from different axes
    // (zero jerk, not a hit with threshold 0) and enough hits for a catch.
    send_sample(fixed_sample(-32768, -32768, -32768));
    send_sample(fixed_sample(0, 0, 0));
    send_sample(fixed_sample(32767, 32767, 32767));
    send_sample(fixed_sample(32767, 32767, 32767));
    send_sample(fixed_sample(-32768, 0, 0));
    send_sample(fixed_sample(0, -32768, 0));
    send_sample(fixed_sample(0, 0, -32768));
    send_sample(fixed_sample(1, -1, 1));
    send_sample(fixed_sample(-1, 1, -1));
    send_sample(fixed_sample(32767, 0, 0));
    send_sample(fixed_sample(0, 0, 0));
    send_sample(fixed_sample(32767, 0, 0));
    send_sample(fixed_sample(0, 0, 0));
    send_sample(fixed_sample(32767, 0, 0));
    send_sample(fixed_sample(0, 0, 0));
    tick_now += 6000;
    send_sample(fixed_sample(0, 0, 0));
    send_sample(fixed_sample(-32768, 32767, -32768));

    tick_now = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      program_phase(p);
      // one phase runs with no gaps on either side at all
      send_idle_en = (p != 3);
      recv_idle_en = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) mid_phase(p);
        if (p == 2 && i == 20) stall_req = 1'b1;
        send_sample(next_sample());
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("bite_jerk_density_detector verification clean");
    else
      $display("bite_jerk_density_detector verification failed");
    $finish;
  end

endmodule
